FILE: rtl/psvm_pkg.sv
// Package for the polyphonic sine voice mixer: widths, codes, state types
// and the sine table builder. No dependencies; every other file uses it.
`default_nettype none

package psvm_pkg;

   // Voice bank size and sine table geometry
   localparam int VOICES          = 64;
   localparam int VID_W           = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SINE_TABLE_BITS = 10;
   localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int SINE_W          = 16;
   localparam int SINE_MAX        = 32767;

   // Port field widths
   localparam int CMD_W     = 1;
   localparam int ID_W      = 6;
   localparam int STEP_W    = 32;
   localparam int LEVEL_W   = 16;
   localparam int PHASE_W   = 32;
   localparam int BLK_W     = 16;
   localparam int TOTAL_W   = 16;
   localparam int FADE_W    = 10;
   localparam int SAMPLE_W  = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd344;
   localparam logic [FADE_W-1:0]  FADE_RESET  = 10'd50;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE  = 1'd1;

   // Mix and envelope datapath widths
   localparam int PROD_W   = 32;
   localparam int ACC_W    = PROD_W + $clog2(VOICES);
   localparam int MAG_W    = ACC_W - 1;
   localparam int ML_W     = (MAG_W + 1) / 2;
   localparam int MH_W     = MAG_W - ML_W;
   localparam int P1_W     = 2 * FADE_W;
   localparam int SCALE_W  = 15;
   localparam int P2_W     = P1_W + SCALE_W;
   localparam int F2_W     = 2 * FADE_W;
   localparam int X_W      = MAG_W + P2_W;
   localparam int XL_W     = ML_W + P2_W;
   localparam int XH_W     = MH_W + P2_W;
   localparam int MIX_FRAC = 30;
   localparam int Y_W      = X_W - MIX_FRAC;
   localparam int Q_W      = Y_W - F2_W;
   localparam int DCNT_W   = $clog2(Q_W);

   // Polynomial coefficients for sin(pi/2 x), Q30
   localparam longint unsigned COEF_C1 = 64'd1686629713;
   localparam longint unsigned COEF_C3 = 64'd693598669;
   localparam longint unsigned COEF_C5 = 64'd85569305;
   localparam longint unsigned COEF_C7 = 64'd5026994;
   localparam longint unsigned COEF_C9 = 64'd172272;
   localparam longint unsigned Q30_HALF = 64'd536870912;

   typedef logic signed [SINE_W-1:0] sine_rom_type [TABLE_SIZE];

   typedef struct packed {
      logic               en;
      logic [VID_W-1:0]   id;
      logic [STEP_W-1:0]  step;
      logic [LEVEL_W-1:0] level;
   } voice_upd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_SCALE,
      ST_HOLD
   } psvm_state_type;

   typedef enum logic [2:0] {
      EV_IDLE,
      EV_PROD,
      EV_SCALE,
      EV_MLO,
      EV_MHI,
      EV_SUM,
      EV_DIV,
      EV_DONE
   } env_state_type;

   // One quarter-wave entry from the truncated odd series
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned x3;
      longint unsigned x5;
      longint unsigned x7;
      longint unsigned x9;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned s;
      longint unsigned v;
      x   = 64'(k) << (32 - SINE_TABLE_BITS);
      x2  = (x * x) >> 30;
      x3  = (x2 * x) >> 30;
      x5  = (x3 * x2) >> 30;
      x7  = (x5 * x2) >> 30;
      x9  = (x7 * x2) >> 30;
      pos = COEF_C1 * x + COEF_C5 * x5 + COEF_C9 * x9;
      neg = COEF_C3 * x3 + COEF_C7 * x7;
      s   = (pos > neg) ? ((pos - neg) >> 30) : 64'd0;
      v   = (s * 64'(SINE_MAX) + Q30_HALF) >> 30;
      if (v > 64'(SINE_MAX)) begin
         v = 64'(SINE_MAX);
      end
      return v[SINE_W-1:0];
   endfunction

   // Full table: mirror and negate the quarter wave
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      int unsigned  quad;
      int unsigned  k;
      logic [SINE_W-1:0] v;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         quad = (i >> QUARTER_BITS) & 3;
         k    = i & ((1 << QUARTER_BITS) - 1);
         if (quad[0]) begin
            v = quarter_sine((1 << QUARTER_BITS) - k);
         end else begin
            v = quarter_sine(k);
         end
         rom[i] = quad[1] ? -$signed(v) : $signed(v);
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/psvm_if.sv
// Channel interfaces of the voice mixer: request items and result samples.
// Depends on psvm_pkg for field widths.
`default_nettype none

interface psvm_req_if;
   logic                            valid;
   logic                            ready;
   logic [psvm_pkg::CMD_W-1:0]      cmd;
   logic [psvm_pkg::ID_W-1:0]       voice_sel;
   logic [psvm_pkg::STEP_W-1:0]     phase_step;
   logic [psvm_pkg::LEVEL_W-1:0]    voice_gain;
   logic [psvm_pkg::BLK_W-1:0]      block_index;

   modport source (output valid, cmd, voice_sel, phase_step, voice_gain, block_index,
                   input ready);
   modport sink   (input valid, cmd, voice_sel, phase_step, voice_gain, block_index,
                   output ready);
endinterface

interface psvm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [psvm_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/psvm_voice_bank.sv
// Voice bank: parameter and phase memories, sine ROM and the mix accumulator.
// Walks every voice slot once per sample. Depends on psvm_pkg.
`default_nettype none

module psvm_voice_bank (
   input  logic                                clock,
   input  logic                                reset,
   input  psvm_pkg::voice_upd_type             upd,
   input  logic                                start,
   output logic                                done,
   output logic signed [psvm_pkg::ACC_W-1:0]   mix
);

   localparam psvm_pkg::sine_rom_type SINE_ROM = psvm_pkg::build_sine_rom();
   localparam int PARAM_W = psvm_pkg::STEP_W + psvm_pkg::LEVEL_W;

   // Storage
   logic [psvm_pkg::VOICES-1:0]       active_ff;
   logic [PARAM_W-1:0]                param_mem [psvm_pkg::VOICES];
   logic [psvm_pkg::PHASE_W-1:0]      phase_mem [psvm_pkg::VOICES];

   // Sweep control
   logic                              swp_ff;
   logic [psvm_pkg::VID_W-1:0]        addr_ff;
   logic                              addr_last;

   // Stage 1: memory read data
   logic                              s1_act_ff;
   logic                              s1_last_ff;
   logic [psvm_pkg::VID_W-1:0]        s1_addr_ff;
   logic [PARAM_W-1:0]                param_rd_ff;
   logic [psvm_pkg::PHASE_W-1:0]      phase_rd_ff;

   // Stage 2: sine lookup
   logic                              s2_act_ff;
   logic                              s2_last_ff;
   logic signed [psvm_pkg::SINE_W-1:0] sine_ff;
   logic [psvm_pkg::LEVEL_W-1:0]      level_s2_ff;

   // Stage 3: product
   logic                              s3_last_ff;
   logic signed [psvm_pkg::PROD_W-1:0] prod_ff;
   logic signed [psvm_pkg::PROD_W-1:0] prod_in;

   logic signed [psvm_pkg::ACC_W-1:0] acc_ff;
   logic                              done_ff;

   // Phase memory port
   logic                              ph_we;
   logic [psvm_pkg::VID_W-1:0]        ph_wa;
   logic [psvm_pkg::PHASE_W-1:0]      ph_wd;

   assign addr_last = (addr_ff == psvm_pkg::VID_W'(psvm_pkg::VOICES - 1));

   // Mark voices active on update
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (upd.en) begin
         active_ff[upd.id] <= 1'b1;
      end
   end

   // Parameter memory: written by updates, read by the sweep
   always_ff @(posedge clock) begin
      if (upd.en) begin
         param_mem[upd.id] <= {upd.step, upd.level};
      end
      param_rd_ff <= param_mem[addr_ff];
   end

   // Phase write: advance during the sweep, zero on first activation
   always_comb begin
      if (s1_act_ff) begin
         ph_we = 1'b1;
         ph_wa = s1_addr_ff;
         ph_wd = phase_rd_ff + param_rd_ff[psvm_pkg::LEVEL_W +: psvm_pkg::STEP_W];
      end else begin
         ph_we = upd.en && !active_ff[upd.id];
         ph_wa = upd.id;
         ph_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ph_we) begin
         phase_mem[ph_wa] <= ph_wd;
      end
      phase_rd_ff <= phase_mem[addr_ff];
   end

   // Sweep address counter
   always_ff @(posedge clock) begin
      if (reset) begin
         swp_ff <= 1'b0;
      end else if (start) begin
         swp_ff <= 1'b1;
      end else if (swp_ff && addr_last) begin
         swp_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         addr_ff <= '0;
      end else if (swp_ff) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   // Pipeline control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_act_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
         s3_last_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         s1_act_ff  <= swp_ff && active_ff[addr_ff];
         s1_last_ff <= swp_ff && addr_last;
         s2_act_ff  <= s1_act_ff;
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
         done_ff    <= s3_last_ff;
      end
   end

   // Sine lookup and product datapath
   assign prod_in = s2_act_ff ?
      psvm_pkg::PROD_W'(sine_ff) * psvm_pkg::PROD_W'($signed({1'b0, level_s2_ff})) : '0;

   always_ff @(posedge clock) begin
      s1_addr_ff  <= addr_ff;
      sine_ff     <= SINE_ROM[phase_rd_ff[psvm_pkg::PHASE_W-1 -: psvm_pkg::SINE_TABLE_BITS]];
      level_s2_ff <= param_rd_ff[psvm_pkg::LEVEL_W-1:0];
      prod_ff     <= prod_in;
   end

   // Accumulate the mix
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_ff + psvm_pkg::ACC_W'(prod_ff);
      end
   end

   assign done = done_ff;
   assign mix  = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/psvm_envelope.sv
// Envelope and output scaling: fade ramps, scale by 32767, divide by fade^2
// with a bit-per-cycle restoring divider, saturate. Depends on psvm_pkg.
`default_nettype none

module psvm_envelope (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [psvm_pkg::ACC_W-1:0]     mix,
   input  logic [psvm_pkg::BLK_W-1:0]            blk,
   input  logic [psvm_pkg::TOTAL_W-1:0]          total,
   input  logic [psvm_pkg::FADE_W-1:0]           fade,
   output logic                                  done,
   output logic signed [psvm_pkg::SAMPLE_W-1:0]  sample
);

   psvm_pkg::env_state_type state_ff;
   psvm_pkg::env_state_type state_in;

   logic [psvm_pkg::FADE_W-1:0]   f_ff;
   logic [psvm_pkg::FADE_W-1:0]   ni_ff;
   logic [psvm_pkg::FADE_W-1:0]   no_ff;
   logic                          neg_ff;
   logic [psvm_pkg::MAG_W-1:0]    mag_ff;
   logic [psvm_pkg::P1_W-1:0]     p1_ff;
   logic [psvm_pkg::F2_W-1:0]     f2_ff;
   logic [psvm_pkg::P2_W-1:0]     p2_ff;
   logic [psvm_pkg::XL_W-1:0]     xl_ff;
   logic [psvm_pkg::XH_W-1:0]     xh_ff;
   logic [psvm_pkg::Y_W-1:0]      rq_ff;
   logic [psvm_pkg::Y_W-1:0]      rq_in;
   logic [psvm_pkg::DCNT_W-1:0]   cnt_ff;
   logic                          done_ff;
   logic signed [psvm_pkg::SAMPLE_W-1:0] sample_ff;

   // Input decode
   logic [psvm_pkg::FADE_W-1:0]   f_eff;
   logic [psvm_pkg::TOTAL_W-1:0]  rem;
   logic [psvm_pkg::FADE_W-1:0]   ni_in;
   logic [psvm_pkg::FADE_W-1:0]   no_in;
   logic [psvm_pkg::ACC_W-1:0]    mag_full;

   // Divider step
   logic [psvm_pkg::F2_W:0]       trial;
   logic                          ge;
   logic [psvm_pkg::F2_W:0]       diff;
   logic [psvm_pkg::X_W-1:0]      x_sum;

   // Output stage
   logic [psvm_pkg::Q_W-1:0]      quo;
   logic [psvm_pkg::SCALE_W-1:0]  val;
   logic [psvm_pkg::SAMPLE_W-1:0] mag_out;
   logic                          fin;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psvm_pkg::EV_IDLE:  if (start) state_in = psvm_pkg::EV_PROD;
         psvm_pkg::EV_PROD:  state_in = psvm_pkg::EV_SCALE;
         psvm_pkg::EV_SCALE: state_in = psvm_pkg::EV_MLO;
         psvm_pkg::EV_MLO:   state_in = psvm_pkg::EV_MHI;
         psvm_pkg::EV_MHI:   state_in = psvm_pkg::EV_SUM;
         psvm_pkg::EV_SUM:   state_in = psvm_pkg::EV_DIV;
         psvm_pkg::EV_DIV:   if (cnt_ff == '0) state_in = psvm_pkg::EV_DONE;
         psvm_pkg::EV_DONE:  state_in = psvm_pkg::EV_IDLE;
         default:            state_in = psvm_pkg::EV_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      fin = (state_ff == psvm_pkg::EV_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psvm_pkg::EV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= fin;
      end
   end

   // Ramp factors: fade of zero counts as one
   always_comb begin
      f_eff    = (fade == '0) ? psvm_pkg::FADE_W'(1) : fade;
      ni_in    = (blk < psvm_pkg::BLK_W'(f_eff)) ? blk[psvm_pkg::FADE_W-1:0] : f_eff;
      rem      = (total > blk) ? (total - blk) : '0;
      no_in    = (rem < psvm_pkg::TOTAL_W'(f_eff)) ? rem[psvm_pkg::FADE_W-1:0] : f_eff;
      mag_full = mix[psvm_pkg::ACC_W-1] ? psvm_pkg::ACC_W'(-mix) : psvm_pkg::ACC_W'(mix);
   end

   // Restoring divide of the scaled magnitude by fade^2, one bit a cycle
   always_comb begin
      trial = rq_ff[psvm_pkg::Y_W-1 -: (psvm_pkg::F2_W + 1)];
      ge    = (trial >= {1'b0, f2_ff});
      diff  = ge ? (trial - {1'b0, f2_ff}) : trial;
      rq_in = {diff[psvm_pkg::F2_W-1:0], rq_ff[psvm_pkg::Q_W-2:0], ge};
      x_sum = (psvm_pkg::X_W'(xh_ff) << psvm_pkg::ML_W) + psvm_pkg::X_W'(xl_ff);
   end

   // Saturate and restore the sign
   always_comb begin
      quo     = rq_ff[psvm_pkg::Q_W-1:0];
      val     = (quo > psvm_pkg::Q_W'(psvm_pkg::SINE_MAX)) ?
                psvm_pkg::SCALE_W'(psvm_pkg::SINE_MAX) : quo[psvm_pkg::SCALE_W-1:0];
      mag_out = {1'b0, val};
   end

   // Datapath registers, one operation per state
   always_ff @(posedge clock) begin
      case (state_ff)
         psvm_pkg::EV_IDLE: begin
            if (start) begin
               f_ff   <= f_eff;
               ni_ff  <= ni_in;
               no_ff  <= no_in;
               neg_ff <= mix[psvm_pkg::ACC_W-1];
               mag_ff <= mag_full[psvm_pkg::MAG_W-1:0];
            end
         end
         psvm_pkg::EV_PROD: begin
            p1_ff <= psvm_pkg::P1_W'(ni_ff) * psvm_pkg::P1_W'(no_ff);
            f2_ff <= psvm_pkg::F2_W'(f_ff) * psvm_pkg::F2_W'(f_ff);
         end
         psvm_pkg::EV_SCALE: begin
            p2_ff <= psvm_pkg::P2_W'({p1_ff, {psvm_pkg::SCALE_W{1'b0}}})
                     - psvm_pkg::P2_W'(p1_ff);
         end
         psvm_pkg::EV_MLO: begin
            xl_ff <= psvm_pkg::XL_W'(mag_ff[psvm_pkg::ML_W-1:0]) * psvm_pkg::XL_W'(p2_ff);
         end
         psvm_pkg::EV_MHI: begin
            xh_ff <= psvm_pkg::XH_W'(mag_ff[psvm_pkg::MAG_W-1:psvm_pkg::ML_W])
                     * psvm_pkg::XH_W'(p2_ff);
         end
         psvm_pkg::EV_SUM: begin
            rq_ff  <= x_sum[psvm_pkg::X_W-1:psvm_pkg::MIX_FRAC];
            cnt_ff <= psvm_pkg::DCNT_W'(psvm_pkg::Q_W - 1);
         end
         psvm_pkg::EV_DIV: begin
            rq_ff  <= rq_in;
            cnt_ff <= cnt_ff - 1'b1;
         end
         psvm_pkg::EV_DONE: begin
            sample_ff <= neg_ff ? $signed(-mag_out) : $signed(mag_out);
         end
         default: begin
         end
      endcase
   end

   assign done   = done_ff;
   assign sample = sample_ff;

endmodule

`default_nettype wire

FILE: rtl/polyphonic_sine_voice_mixer_top.sv
// Top level of the polyphonic sine voice mixer: handshake, register port,
// item sequencing and the result register. Depends on psvm_pkg, psvm_if,
// psvm_voice_bank and psvm_envelope.
//
// Usage:
//   req_chan carries items. cmd update writes phase_step and voice_gain
//   into slot voice_sel and marks the voice active; it gives no result.
//   cmd sample mixes all active voices for block_index and gives one
//   sample on rsp_chan. For a sample item the voice memories are swept
//   one slot a cycle (plus a 4-stage read/lookup/multiply/add pipeline),
//   then the envelope runs five product and sum steps and a restoring
//   divider of Q_W (22) steps.
//   One item is in work at a time; req_chan.ready is high between items,
//   also while a finished sample still waits in the result register.
//   If rsp_chan stalls, a finished sample waits inside until the result
//   register frees up; no item is taken meanwhile.
//   csr_we writes total_blocks (index 0) or fade_blocks (index 1); write
//   only between items. Reset (synchronous) clears all voices to inactive
//   and loads total 344 and fade 50 (no clearing pass; phase is zeroed on first update).
`default_nettype none

module polyphonic_sine_voice_mixer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   psvm_req_if.sink                             req_chan,
   psvm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [psvm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psvm_pkg::CSR_W-1:0]           csr_wdata
);

   psvm_pkg::psvm_state_type state_ff;
   psvm_pkg::psvm_state_type state_in;

   logic [psvm_pkg::TOTAL_W-1:0]  total_ff;
   logic [psvm_pkg::TOTAL_W-1:0]  total_in;
   logic [psvm_pkg::FADE_W-1:0]   fade_ff;
   logic [psvm_pkg::FADE_W-1:0]   fade_in;
   logic [psvm_pkg::BLK_W-1:0]    blk_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [psvm_pkg::SAMPLE_W-1:0] rsp_sample_ff;

   logic                          req_ready;
   logic                          req_xfer;
   logic                          smp_start;
   logic                          env_start;
   logic                          rsp_load;
   logic                          slot_free;

   psvm_pkg::voice_upd_type       upd;
   logic                          bank_done;
   logic signed [psvm_pkg::ACC_W-1:0] bank_mix;
   logic                          env_done;
   logic signed [psvm_pkg::SAMPLE_W-1:0] env_sample;

   assign req_xfer  = req_chan.valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psvm_pkg::ST_IDLE: begin
            if (req_xfer && (req_chan.cmd == psvm_pkg::CMD_SAMPLE)) begin
               state_in = psvm_pkg::ST_MIX;
            end
         end
         psvm_pkg::ST_MIX:   if (bank_done) state_in = psvm_pkg::ST_SCALE;
         psvm_pkg::ST_SCALE: if (env_done) state_in = psvm_pkg::ST_HOLD;
         psvm_pkg::ST_HOLD:  if (slot_free) state_in = psvm_pkg::ST_IDLE;
         default:            state_in = psvm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = (state_ff == psvm_pkg::ST_IDLE);
      smp_start = (state_ff == psvm_pkg::ST_IDLE) && req_chan.valid
                  && (req_chan.cmd == psvm_pkg::CMD_SAMPLE);
      env_start = (state_ff == psvm_pkg::ST_MIX) && bank_done;
      rsp_load  = (state_ff == psvm_pkg::ST_HOLD) && slot_free;
   end

   // Update request toward the voice bank; drop ids past the bank
   always_comb begin
      upd.en    = req_xfer && (req_chan.cmd == psvm_pkg::CMD_UPDATE)
                  && (32'(req_chan.voice_sel) < psvm_pkg::VOICES);
      upd.id    = psvm_pkg::VID_W'(req_chan.voice_sel);
      upd.step  = req_chan.phase_step;
      upd.level = req_chan.voice_gain;
   end

   // Register writes
   always_comb begin
      total_in = total_ff;
      fade_in  = fade_ff;
      if (csr_we) begin
         unique case (csr_index)
            psvm_pkg::CSR_TOTAL: total_in = csr_wdata[psvm_pkg::TOTAL_W-1:0];
            psvm_pkg::CSR_FADE:  fade_in  = csr_wdata[psvm_pkg::FADE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Result register: load a finished sample, drop it on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psvm_pkg::ST_IDLE;
         total_ff     <= psvm_pkg::TOTAL_RESET;
         fade_ff      <= psvm_pkg::FADE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         fade_ff      <= fade_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payloads
   always_ff @(posedge clock) begin
      if (smp_start) begin
         blk_ff <= req_chan.block_index;
      end
      if (rsp_load) begin
         rsp_sample_ff <= env_sample;
      end
   end

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = rsp_sample_ff;

   psvm_voice_bank u_bank (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .start (smp_start),
      .done  (bank_done),
      .mix   (bank_mix)
   );

   psvm_envelope u_env (
      .clock  (clock),
      .reset  (reset),
      .start  (env_start),
      .mix    (bank_mix),
      .blk    (blk_ff),
      .total  (total_ff),
      .fade   (fade_ff),
      .done   (env_done),
      .sample (env_sample)
   );

   // The bank reports completion only while a sample is mixing
   a_bank_done_in_mix: assert property (@(posedge clock) disable iff (reset)
      bank_done |-> (state_ff == psvm_pkg::ST_MIX))
      else $error("voice bank done outside mix phase");

   // The envelope reports completion only while scaling
   a_env_done_in_scale: assert property (@(posedge clock) disable iff (reset)
      env_done |-> (state_ff == psvm_pkg::ST_SCALE))
      else $error("envelope done outside scale phase");

   // An accepted sample item starts the sweep
   a_sample_starts_mix: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_chan.cmd == psvm_pkg::CMD_SAMPLE)) |=> (state_ff == psvm_pkg::ST_MIX))
      else $error("sample transfer did not start the mix");

   // Loads go only into a free result register; after a load it holds a valid result
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result register not filled after load");

endmodule

`default_nettype wire
